[rtl/laser_scan_point_transform_unit_assert.svh]
// Assertion macros for the laser scan point transform unit.
// Used by the RTL modules that carry concurrent checks.
`ifndef LASER_SCAN_POINT_TRANSFORM_UNIT_ASSERT_SVH
`define LASER_SCAN_POINT_TRANSFORM_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LSPT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lspt check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define LSPT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lspt check failed");
`endif

[rtl/lspt_pkg.sv]
// Package for the laser scan point transform unit.
// Holds register indexes, item types, CORDIC angle table and fixed constants.
`default_nettype none
package lspt_pkg;
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_COS = 3'd0, REG_ROT_SIN = 3'd1, REG_OFF_X = 3'd2, REG_OFF_Y = 3'd3,
    REG_START = 3'd4, REG_STEP = 3'd5, REG_RLOW = 3'd6, REG_RUP = 3'd7
  } cfg_reg_e;

  localparam logic [15:0] InvK = 16'd39797;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [17:0] BoxXMin = 18'sd410;
  localparam logic signed [17:0] BoxXMax = 18'sd8192;
  localparam logic signed [17:0] BoxYMin = -18'sd1228;
  localparam logic signed [17:0] BoxYMax = 18'sd1228;
  localparam int unsigned CW = 40;

  typedef struct packed {
    logic [15:0] range;
    logic [15:0] angle;
    logic        range_valid;
    logic [9:0]  index;
  } front_item_t;

  typedef struct packed {
    logic signed [17:0] px;
    logic signed [17:0] py;
    logic [16:0]        radius;
    logic [15:0]        bear;
    logic               range_valid;
    logic               in_box;
    logic [9:0]         index;
  } result_t;

  function automatic logic signed [33:0] atan_at(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd536870912;  5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;  5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;   5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;   5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;    5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;    5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;    5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;     5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;     5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;       5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;       5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[rtl/lspt_front.sv]
// Front part: register file, beam angle and index tracking, range check.
// Depends on lspt_pkg.
`default_nettype none
module lspt_front #(
  parameter int unsigned MaxSamples = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [15:0]              cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [15:0]              raw_range_i,
  input  wire logic                     scan_start_i,
  output logic                          push_o,
  input  wire logic                     q_full_i,
  output lspt_pkg::front_item_t         item_o,
  output logic [15:0]                   rot_cos_o,
  output logic [15:0]                   rot_sin_o,
  output logic [15:0]                   off_x_o,
  output logic [15:0]                   off_y_o
);
  import lspt_pkg::*;
  localparam int unsigned IdxW = $clog2(MaxSamples);
  logic [15:0] start_q, step_q, rlow_q, rup_q, ang_q, ang_d;
  logic [15:0] cos_q, sin_q, ox_q, oy_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW:0] idx_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !q_full_i;
  assign push_o = in_valid_i && !q_full_i;
  assign idx_inc = {1'b0, idx_q} + (IdxW+1)'(1);

  always_comb begin
    if (scan_start_i) begin
      ang_d = start_q;
      idx_d = '0;
    end else begin
      ang_d = ang_q + step_q;
      idx_d = (idx_inc >= (IdxW+1)'(MaxSamples)) ? '0 : idx_inc[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 16'd16384; sin_q <= '0; ox_q <= 16'd426; oy_q <= '0;
      start_q <= '0; step_q <= '0; rlow_q <= '0; rup_q <= 16'hffff;
      ang_q <= '0; idx_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ROT_COS: cos_q <= cfg_data_i;
          REG_ROT_SIN: sin_q <= cfg_data_i;
          REG_OFF_X:   ox_q <= cfg_data_i;
          REG_OFF_Y:   oy_q <= cfg_data_i;
          REG_START:   start_q <= cfg_data_i;
          REG_STEP:    step_q <= cfg_data_i;
          REG_RLOW:    rlow_q <= cfg_data_i;
          REG_RUP:     rup_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (push_o) begin
        ang_q <= ang_d;
        idx_q <= idx_d;
      end
    end
  end

  assign item_o.range = raw_range_i;
  assign item_o.angle = ang_d;
  assign item_o.range_valid = (raw_range_i > rlow_q) && (raw_range_i < rup_q);
  assign item_o.index = 10'(idx_d);
  assign rot_cos_o = cos_q;
  assign rot_sin_o = sin_q;
  assign off_x_o = ox_q;
  assign off_y_o = oy_q;
endmodule
`default_nettype wire

[rtl/lspt_queue.sv]
// Short FIFO between front and back parts.
// Depends on lspt_pkg.
`default_nettype none
module lspt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  lspt_pkg::front_item_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output lspt_pkg::front_item_t data_o
);
  import lspt_pkg::*;
  front_item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

[rtl/lspt_back.sv]
// Back part: rotation CORDIC, mounting transform, vectoring CORDIC, output register.
// Depends on lspt_pkg and the assertion macro header.
`default_nettype none
`include "laser_scan_point_transform_unit_assert.svh"
module lspt_back #(
  parameter int unsigned CordicStages = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  lspt_pkg::front_item_t item_i,
  output logic                  pop_o,
  input  wire logic [15:0]      rot_cos_i,
  input  wire logic [15:0]      rot_sin_i,
  input  wire logic [15:0]      off_x_i,
  input  wire logic [15:0]      off_y_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lspt_pkg::result_t     res_o
);
  import lspt_pkg::*;
  localparam int unsigned NStg = (CordicStages < 24) ? CordicStages : 24;
  localparam int unsigned StW = 5;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_ROT = 6'b000010, S_MUL = 6'b000100,
    S_SUM = 6'b001000, S_VEC = 6'b010000, S_FIN = 6'b100000
  } state_e;

  state_e st_q, st_d;
  logic [StW-1:0] it_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [33:0] z_q, at;
  logic signed [49:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [50:0] sum_x, sum_y;
  logic signed [17:0] px_q, py_q;
  logic [15:0] bear_n;
  logic [16:0] radius_n;
  logic signed [CW+16:0] mag;
  logic signed [33:0] zr;
  logic signed [33:0] sx, sy;
  logic signed [17:0] px_s, py_s;
  logic rv_q, ob_busy_q;
  logic [9:0] ix_q;
  logic vdir, rdir;

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign at = atan_at(it_q);
  assign rdir = !z_q[33];
  assign vdir = (y_q > 0);
  assign pop_o = (st_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = ob_busy_q;

  function automatic logic signed [17:0] sat18(input logic signed [33:0] v);
    if (v > 34'sd131071) return 18'sd131071;
    if (v < -34'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  always_comb begin
    sum_x = 51'(m0_q) - 51'(m1_q) + (51'sd1 <<< 29);
    sum_y = 51'(m2_q) + 51'(m3_q) + (51'sd1 <<< 29);
    sx = 34'(sum_x >>> 30) + 34'(signed'(off_x_i));
    sy = 34'(sum_y >>> 30) + 34'(signed'(off_y_i));
    px_s = sat18(sx);
    py_s = sat18(sy);
  end

  always_comb begin
    logic signed [CW-1:0] xc;
    xc = x_q[CW-1] ? '0 : x_q;
    mag = ((CW+17)'(xc) * (CW+17)'(signed'({1'b0, InvK})) + (57'sd1 <<< 31)) >>> 32;
    radius_n = (mag > 57'sd131071) ? 17'd131071 : mag[16:0];
    zr = (z_q + 34'sd32768) >>> 16;
    bear_n = zr[15:0];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (!q_empty_i) st_d = S_ROT;
      S_ROT:  if (it_q == StW'(NStg-1)) st_d = S_MUL;
      S_MUL:  st_d = S_SUM;
      S_SUM:  st_d = S_VEC;
      S_VEC:  if (it_q == StW'(NStg-1) || (px_q == '0 && py_q == '0)) st_d = S_FIN;
      S_FIN:  if (!ob_busy_q || out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; it_q <= '0; ob_busy_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == S_ROT || st_q == S_VEC) it_q <= (st_d != st_q) ? '0 : it_q + StW'(1);
      if (st_q == S_FIN && st_d == S_IDLE) ob_busy_q <= 1'b1;
      else if (out_ready_i) ob_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        logic signed [33:0] z0;
        logic signed [CW-1:0] x0;
        x0 = CW'($signed({1'b0, 32'(item_i.range) * 32'(InvK)}));
        z0 = 34'(signed'(item_i.angle)) <<< 16;
        rv_q <= item_i.range_valid;
        ix_q <= item_i.index;
        if (z0 > QuarterTurn) begin
          x_q <= '0; y_q <= x0; z_q <= z0 - QuarterTurn;
        end else if (z0 < -QuarterTurn) begin
          x_q <= '0; y_q <= -x0; z_q <= z0 + QuarterTurn;
        end else begin
          x_q <= x0; y_q <= '0; z_q <= z0;
        end
      end
      S_ROT: begin
        if (rdir) begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
        end
      end
      S_MUL: begin
        m0_q <= 50'(signed'(rot_cos_i)) * 50'(signed'(x_q[33:0]));
        m1_q <= 50'(signed'(rot_sin_i)) * 50'(signed'(y_q[33:0]));
        m2_q <= 50'(signed'(rot_sin_i)) * 50'(signed'(x_q[33:0]));
        m3_q <= 50'(signed'(rot_cos_i)) * 50'(signed'(y_q[33:0]));
      end
      S_SUM: begin
        logic signed [CW-1:0] vx, vy;
        vx = CW'(px_s) <<< 16;
        vy = CW'(py_s) <<< 16;
        px_q <= px_s; py_q <= py_s;
        if (vx < 0) begin
          if (vy >= 0) begin
            x_q <= vy; y_q <= -vx; z_q <= QuarterTurn;
          end else begin
            x_q <= -vy; y_q <= vx; z_q <= -QuarterTurn;
          end
        end else begin
          x_q <= vx; y_q <= vy; z_q <= '0;
        end
      end
      S_VEC: begin
        if (vdir) begin
          x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
        end else begin
          x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
        end
      end
      S_FIN: begin
        if (!ob_busy_q || out_ready_i) begin
          res_o.px <= px_q;
          res_o.py <= py_q;
          res_o.radius <= (px_q == '0 && py_q == '0) ? '0 : radius_n;
          res_o.bear <= (px_q == '0 && py_q == '0) ? '0 : bear_n;
          res_o.range_valid <= rv_q;
          res_o.in_box <= (px_q >= BoxXMin) && (px_q <= BoxXMax) &&
                          (py_q >= BoxYMin) && (py_q <= BoxYMax);
          res_o.index <= ix_q;
        end
      end
      default: ;
    endcase
  end

  `LSPT_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, pop_o, st_q == S_IDLE)
  `LSPT_ASSERT_NXT(a_pop_rot, clk_i, rst_ni, pop_o, st_q == S_ROT)
  `LSPT_ASSERT_IMP(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i && st_q == S_FIN,
                   st_d == S_FIN)
endmodule
`default_nettype wire

[rtl/laser_scan_point_transform_unit.sv]
// Top level of the laser scan point transform unit.
// Depends on lspt_pkg, lspt_front, lspt_queue and lspt_back.
// Each item passes in order through the shared CORDIC datapath of the back part: taking
// the item, the rotation pass at one micro-rotation per cycle, the products, the sum, the
// vectoring pass at one micro-rotation per cycle and the result register; a point at the
// origin ends the vectoring pass after its first micro-rotation, and a result not yet
// taken holds the back part. Meanwhile the front part fills a two-entry queue until full.
`default_nettype none
module laser_scan_point_transform_unit #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // raw_range
  input  wire logic        s_axis_tuser,  // scan_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // point_x[17:0], point_y[35:18], base_distance[52:36], base_bearing[68:53],
  // sample_index[78:69], zero pad
  output logic [79:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser   // range_valid, in_front_box
);
  import lspt_pkg::*;
  front_item_t fi, qo;
  result_t res;
  logic push, full, empty, pop;
  logic [15:0] rc, rs, ox, oy;

  lspt_front #(.MaxSamples(MAX_SAMPLES)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .raw_range_i(s_axis_tdata), .scan_start_i(s_axis_tuser),
    .push_o(push), .q_full_i(full), .item_o(fi),
    .rot_cos_o(rc), .rot_sin_o(rs), .off_x_o(ox), .off_y_o(oy));

  lspt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fi), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(qo));

  lspt_back #(.CordicStages(CORDIC_STAGES)) u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .item_i(qo), .pop_o(pop),
    .rot_cos_i(rc), .rot_sin_i(rs), .off_x_i(ox), .off_y_i(oy),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {1'b0, res.index, res.bear, res.radius, res.py, res.px};
  assign m_axis_tuser = {res.in_box, res.range_valid};
endmodule
`default_nettype wire

[bench/lspt_result_checker.sv]
// Result checker for the laser scan point transform unit.
// Watches the register, sample and result channels, predicts each result and compares it.
// Depends on lspt_pkg for the register index names.
module lspt_result_checker #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [15:0] s_range_i,
  input  wire logic        s_start_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [79:0] m_data_i,
  input  wire logic [1:0]  m_user_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               result_count_o
);
  import lspt_pkg::*;

  typedef struct packed {
    logic [17:0] px;
    logic [17:0] py;
    logic [16:0] radius;
    logic [15:0] bear;
    logic        range_valid;
    logic        in_box;
    logic [9:0]  index;
  } point_t;

  localparam longint InvKScale = 39797;
  localparam longint Quarter = 64'sd1073741824;
  localparam int NStages = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  logic signed [15:0] rot_cos, rot_sin, off_x, off_y, start_ang, step_ang;
  logic [15:0]        range_lo, range_hi;
  logic signed [15:0] beam;
  int unsigned        beam_index;
  point_t             expected_points [$];
  int                 fails;
  int                 results;

  assign fail_count_o   = fails;
  assign pending_o      = expected_points.size();
  assign result_count_o = results;

  function automatic longint arc_at(input int i);
    case (i)
      0: return 536870912;   1: return 316933406;   2: return 167458907;
      3: return 85004756;    4: return 42667331;    5: return 21354465;
      6: return 10679838;    7: return 5340245;     8: return 2670163;
      9: return 1335087;     10: return 667544;     11: return 333772;
      12: return 166886;     13: return 83443;      14: return 41722;
      15: return 20861;      16: return 10430;      17: return 5215;
      18: return 2608;       19: return 1304;       20: return 652;
      21: return 326;        22: return 163;        23: return 81;
      default: return 0;
    endcase
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic predict_point(input logic [15:0] r, input logic st, output point_t e);
    longint x, y, z, nx, ny, px, py, distance, bear;
    if (st) begin
      beam = start_ang;
      beam_index = 0;
    end else begin
      beam = beam + step_ang;
      beam_index = (beam_index + 1 >= MAX_SAMPLES) ? 0 : beam_index + 1;
    end
    x = longint'(r) * InvKScale;
    y = 0;
    z = longint'(beam) * 65536;
    if (z > Quarter) begin
      y = x; x = 0; z = z - Quarter;
    end else if (z < -Quarter) begin
      y = -x; x = 0; z = z + Quarter;
    end
    for (int i = 0; i < NStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z = z - arc_at(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z = z + arc_at(i);
      end
      x = nx; y = ny;
    end
    px = round_shift(longint'(rot_cos) * x - longint'(rot_sin) * y, 30) + longint'(off_x);
    py = round_shift(longint'(rot_sin) * x + longint'(rot_cos) * y, 30) + longint'(off_y);
    px = clip(px, -131072, 131071);
    py = clip(py, -131072, 131071);
    if (px == 0 && py == 0) begin
      distance = 0;
      bear = 0;
    end else begin
      x = px * 65536;
      y = py * 65536;
      z = 0;
      if (x < 0) begin
        if (y >= 0) begin
          nx = y; y = -x; x = nx; z = Quarter;
        end else begin
          nx = -y; y = x; x = nx; z = -Quarter;
        end
      end
      for (int i = 0; i < NStages; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z = z + arc_at(i);
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z = z - arc_at(i);
        end
        x = nx; y = ny;
      end
      if (x < 0) x = 0;
      distance = clip(round_shift(x * InvKScale, 32), 0, 131071);
      bear = round_shift(z, 16);
    end
    e.px = px[17:0];
    e.py = py[17:0];
    e.radius = distance[16:0];
    e.bear = bear[15:0];
    e.range_valid = (r > range_lo) && (r < range_hi);
    e.in_box = (px >= 410) && (px <= 8192) && (py >= -1228) && (py <= 1228);
    e.index = beam_index[9:0];
  endtask

  task automatic report(input string field, input longint got, input longint want);
    $display("result %0d: %s is %0h, predicted %0h", results, field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    point_t g;
    if (!rst_ni) begin
      rot_cos = 16'sd16384; rot_sin = '0; off_x = 16'sd426; off_y = '0;
      start_ang = '0; step_ang = '0; range_lo = '0; range_hi = 16'hffff;
      beam = '0;
      beam_index = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_ROT_COS: rot_cos = cfg_data_i;
          REG_ROT_SIN: rot_sin = cfg_data_i;
          REG_OFF_X:   off_x = cfg_data_i;
          REG_OFF_Y:   off_y = cfg_data_i;
          REG_START:   start_ang = cfg_data_i;
          REG_STEP:    step_ang = cfg_data_i;
          REG_RLOW:    range_lo = cfg_data_i;
          REG_RUP:     range_hi = cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_i && m_ready_i) begin
        g.px = m_data_i[17:0];
        g.py = m_data_i[35:18];
        g.radius = m_data_i[52:36];
        g.bear = m_data_i[68:53];
        g.index = m_data_i[78:69];
        g.range_valid = m_user_i[0];
        g.in_box = m_user_i[1];
        if (expected_points.size() == 0) begin
          $display("result %0d arrived with no sample outstanding", results);
          fails++;
        end else begin
          e = expected_points.pop_front();
          if (g.px != e.px) report("point_x", g.px, e.px);
          if (g.py != e.py) report("point_y", g.py, e.py);
          if (g.radius != e.radius) report("base_distance", g.radius, e.radius);
          if (g.bear != e.bear) report("base_bearing", g.bear, e.bear);
          if (g.range_valid != e.range_valid) report("range_valid", g.range_valid, e.range_valid);
          if (g.in_box != e.in_box) report("in_front_box", g.in_box, e.in_box);
          if (g.index != e.index) report("sample_index", g.index, e.index);
        end
        results++;
      end
      if (s_valid_i && s_ready_i) begin
        predict_point(s_range_i, s_start_i, e);
        expected_points = {expected_points, e};
      end
    end
  end
endmodule

[bench/tb_laser_scan_point_transform_unit.sv]
// Testbench top for the laser scan point transform unit.
// Drives registers and range samples with bursty flow; lspt_result_checker does the checking.
// Depends on lspt_pkg, the unit RTL and bench/lspt_result_checker.sv.
module tb_laser_scan_point_transform_unit;
  import lspt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int fail_count, pending, result_count;
  int samples_sent = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  laser_scan_point_transform_unit i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  lspt_result_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready),
    .s_range_i(s_axis_tdata), .s_start_i(s_axis_tuser),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_data_i(m_axis_tdata), .m_user_i(m_axis_tuser),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // receiver: ready pattern switches among always, random and sparse modes, with one long hold-off on request
  initial begin
    int mode;
    int phase;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        if (phase == 0) mode = $urandom_range(0, 2);
        phase = (phase + 1) % 64;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("laser_scan_point_transform_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] c, s, ox, oy, st, sp, lo, hi);
    write_reg(REG_ROT_COS, c);
    write_reg(REG_ROT_SIN, s);
    write_reg(REG_OFF_X, ox);
    write_reg(REG_OFF_Y, oy);
    write_reg(REG_START, st);
    write_reg(REG_STEP, sp);
    write_reg(REG_RLOW, lo);
    write_reg(REG_RUP, hi);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [15:0] r, input logic st);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= r;
    s_axis_tuser <= st;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 10000));
    endcase
  endfunction

  task automatic random_scans(input int n, input int noise_pct);
    int left;
    left = 0;
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_sample(pick_range(), 1'($urandom_range(0, 1)));
      end else begin
        send_sample(pick_range(), left == 0);
        left = (left == 0) ? $urandom_range(1, 120) : left - 1;
      end
    end
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom_range(0, 65535));
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: edge ranges and scan without a start mark
    send_sample(16'd0, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'haaaa, 1'b0);
    drain();

    // no offset: origin point; angles around the quarter turns
    program_regs(16'd16384, 16'd0, 16'd0, 16'd0, 16'd16383, 16'd1, 16'd1, 16'd3000);
    send_sample(16'd0, 1'b1);
    send_sample(16'd1, 1'b0);
    send_sample(16'd3000, 1'b0);
    send_sample(16'd2999, 1'b0);
    send_sample(16'd2, 1'b1);
    drain();
    program_regs(16'd16384, 16'd0, 16'd0, 16'd0, 16'hc001, 16'hffff, 16'd0, 16'hffff);
    send_sample(16'd4000, 1'b1);
    send_sample(16'd4000, 1'b0);
    send_sample(16'd4000, 1'b0);
    send_sample(16'd5000, 1'b1);
    drain();

    // extremes: saturating point, inverted limits, half-turn start
    program_regs(16'hc000, 16'h4000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                 16'hffff, 16'd0);
    send_sample(16'hffff, 1'b1);
    send_sample(16'hffff, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd100, 1'b0);
    drain();

    // random: receiver holds off while samples keep coming
    program_regs(16'd11585, 16'd11585, 16'd426, 16'd0, 16'hc000, 16'd80, 16'd200, 16'd60000);
    long_hold = 1'b1;
    random_scans(120, 10);
    drain();

    // one long run to wrap the sample index
    program_regs(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd64, 16'd0, 16'hffff);
    send_sample(pick_range(), 1'b1);
    repeat (1030) send_sample(pick_range(), 1'b0);
    drain();

    repeat (2) begin
      program_regs(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16());
      random_scans(80, 15);
      drain();
    end

    $display("sent %0d samples over eight register settings, %0d results checked",
             samples_sent, result_count);
    if (fail_count == 0) begin
      $display("laser_scan_point_transform_unit: match");
    end else begin
      $display("laser_scan_point_transform_unit: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/lspt_pkg.sv
rtl/lspt_front.sv
rtl/lspt_queue.sv
rtl/lspt_back.sv
rtl/laser_scan_point_transform_unit.sv
bench/lspt_result_checker.sv
bench/tb_laser_scan_point_transform_unit.sv
